// File: hw/rtl/bc1_bc2_bc3_block_decoder_assert.svh
// Assertion helpers shared by the block decoder RTL.
// Every check samples on the rising edge of clock and is off while reset is high.
`ifndef BC1_BC2_BC3_BLOCK_DECODER_ASSERT_SVH
`define BC1_BC2_BC3_BLOCK_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define BCD_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);
`else
`define BCD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BCD_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: hw/rtl/bcd_pkg.sv
package bcd_pkg;

   localparam int BLOCK_POS_W                = 12;   // block column/row kept in outputs
   localparam int CSR_DATA_W                 = 13;
   localparam int QUEUE_DEPTH                = 2;    // power of two
   localparam int MAX_WIDTH_BLOCKS_DEFAULT   = 4096;

   // block format codes; code 3 decodes as BC3
   localparam logic [1:0] FMT_BC1 = 2'd0;
   localparam logic [1:0] FMT_BC2 = 2'd1;
   localparam logic [1:0] FMT_BC3 = 2'd2;

   typedef enum logic [0:0] {
      CSR_BLOCK_FORMAT    = 1'b0,
      CSR_WIDTH_IN_BLOCKS = 1'b1
   } bcd_csr_type;

   typedef struct packed {
      logic [63:0] color_block;
      logic [63:0] alpha_block;
      logic        start_of_image;
   } bcd_req_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [13:0] pixel_x;
      logic [13:0] pixel_y;
      logic        last_of_block;
   } bcd_rsp_type;

   // one classified block, ready for pixel expansion
   typedef struct packed {
      logic [1:0]             fmt;
      logic [3:0][4:0]        pal_r;
      logic [3:0][5:0]        pal_g;
      logic [3:0][4:0]        pal_b;
      logic [15:0][1:0]       cidx;
      logic [63:0]            abits;
      logic [7:0][7:0]        apal;
      logic [BLOCK_POS_W-1:0] col;
      logic [BLOCK_POS_W-1:0] row;
   } bcd_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } bcd_qstat_type;

endpackage

// File: hw/rtl/bc1_bc2_bc3_block_decoder.sv
// Channel  Ports                          Direction  Moves
// req      req_valid/req_ready/req_data   in         one compressed 4x4 block
// rsp      rsp_valid/rsp_ready/rsp_data   out        one RGBA8 pixel with x,y
// csr      csr_we/csr_index/csr_wdata     in         register write, no wait
//
// Each block yields 16 rsp transactions, one per cycle while rsp_ready holds;
// the pixel output register in the back end sets the rate.
// First pixel is valid after capture, palette build into the queue, and the output load.
// Reset (synchronous) clears position to column 0 row 0, format BC1, width 1.
// Two-deep block queue lets req keep flowing while rsp is stalled, until it fills.
`include "bc1_bc2_bc3_block_decoder_assert.svh"

module bc1_bc2_bc3_block_decoder #(
   parameter int MAX_WIDTH_BLOCKS = bcd_pkg::MAX_WIDTH_BLOCKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // block input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bcd_pkg::bcd_req_type              req_data,
   // pixel output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bcd_pkg::bcd_rsp_type              rsp_data,
   // configuration writes
   input  logic                              csr_we,
   input  bcd_pkg::bcd_csr_type              csr_index,
   input  logic [bcd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bcd_pkg::*;

   bcd_qstat_type qstat;
   bcd_entry_type entry;
   bcd_entry_type head;
   logic          push;
   logic          pop;

   // Front: config regs, block position, palette build.
   bcd_front #(
      .MAX_WIDTH_BLOCKS (MAX_WIDTH_BLOCKS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .qstat     (qstat),
      .push      (push),
      .entry     (entry)
   );

   // Decouples block classification from pixel emission.
   bcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .entry_in (entry),
      .pop      (pop),
      .qstat    (qstat),
      .head     (head)
   );

   // Back: walks the 16 pixels of the head block, one per transaction.
   bcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/bcd_queue.sv
`include "bc1_bc2_bc3_block_decoder_assert.svh"

module bcd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bcd_pkg::bcd_entry_type  entry_in,
   input  logic                    pop,
   output bcd_pkg::bcd_qstat_type  qstat,
   output bcd_pkg::bcd_entry_type  head
);
   import bcd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bcd_entry_type    mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head            = mem_ff[rd_ptr_ff];
   assign qstat.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign qstat.not_empty = (count_ff != '0);

   `BCD_ASSERT_NEVER(a_queue_overflow, push && qstat.full, "push into full block queue")
   `BCD_ASSERT_NEVER(a_queue_underflow, pop && !qstat.not_empty, "pop from empty block queue")

endmodule

// File: hw/rtl/bcd_front.sv
`include "bc1_bc2_bc3_block_decoder_assert.svh"

module bcd_front #(
   parameter int MAX_WIDTH_BLOCKS = bcd_pkg::MAX_WIDTH_BLOCKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bcd_pkg::bcd_req_type              req_data,
   input  logic                              csr_we,
   input  bcd_pkg::bcd_csr_type              csr_index,
   input  logic [bcd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  bcd_pkg::bcd_qstat_type            qstat,
   output logic                              push,
   output bcd_pkg::bcd_entry_type            entry
);
   import bcd_pkg::*;

   localparam int COL_W = ($clog2(MAX_WIDTH_BLOCKS) > BLOCK_POS_W) ?
                          $clog2(MAX_WIDTH_BLOCKS) : BLOCK_POS_W;
   localparam int WID_W = COL_W + 1;

   // x/3 for x up to 126
   function automatic logic [5:0] div3(input logic [6:0] x);
      logic [15:0] p;
      p = 16'(x) * 16'd171;
      return p[14:9];
   endfunction

   // x/7 for x up to 1785
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [23:0] p;
      p = 24'(x) * 24'd4682;
      return p[22:15];
   endfunction

   // x/5 for x up to 1275
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [23:0] p;
      p = 24'(x) * 24'd6554;
      return p[22:15];
   endfunction

   // one interpolated color channel on raw endpoint bits
   function automatic logic [5:0] mix(input logic [5:0] a, input logic [5:0] b,
                                      input logic three, input logic first);
      logic [5:0] a3, b3, a23, b23;
      a3  = div3({1'b0, a});
      b3  = div3({1'b0, b});
      a23 = div3({a, 1'b0});
      b23 = div3({b, 1'b0});
      if (three) begin
         return first ? (a23 + b3) : (a3 + b23);
      end
      return (a >> 1) + (b >> 1);
   endfunction

   // config registers
   logic [1:0]            fmt_ff, fmt_in;
   logic [CSR_DATA_W-1:0] width_ff, width_in;

   // block position
   logic [COL_W-1:0]       col_ff, col_in, col_now;
   logic [BLOCK_POS_W-1:0] row_ff, row_in, row_now;
   logic [WID_W-1:0]       width_eff, col_sum;
   logic                   wrap;

   // stage 1: captured block and alpha numerators
   logic                   s1_valid_ff, s1_valid_in;
   bcd_req_type            s1_req_ff;
   logic [1:0]             s1_fmt_ff;
   logic [BLOCK_POS_W-1:0] s1_col_ff, s1_row_ff;
   logic [5:0][10:0]       s1_num_ff, num_in;
   logic                   s1_gt_ff;

   logic       accept;
   logic [7:0] a0, a1, s1_a0, s1_a1;
   logic       a_gt;

   logic [15:0] e0, e1;
   logic        three;
   logic [5:0]  r0, r1, g0, g1, b0, b1;

   always_comb begin
      fmt_in   = fmt_ff;
      width_in = width_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_FORMAT:    fmt_in   = csr_wdata[1:0];
            CSR_WIDTH_IN_BLOCKS: width_in = csr_wdata;
            default:             fmt_in   = fmt_ff;
         endcase
      end
   end

   assign push        = s1_valid_ff && !qstat.full;
   assign req_ready   = !s1_valid_ff || !qstat.full;
   assign accept      = req_valid && req_ready;
   assign s1_valid_in = accept ? 1'b1 : (push ? 1'b0 : s1_valid_ff);

   always_comb begin
      if (width_ff == '0) begin
         width_eff = WID_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH_BLOCKS)) begin
         width_eff = WID_W'(MAX_WIDTH_BLOCKS);
      end else begin
         width_eff = WID_W'(width_ff);
      end
      col_now = req_data.start_of_image ? '0 : col_ff;
      row_now = req_data.start_of_image ? '0 : row_ff;
      col_sum = WID_W'(col_now) + WID_W'(1);
      wrap    = (col_sum >= width_eff);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         col_in = wrap ? '0 : col_sum[COL_W-1:0];
         row_in = wrap ? row_now + BLOCK_POS_W'(1) : row_now;
      end
   end

   // BC3 numerators; code c+2 sits in slot c
   assign a0   = req_data.alpha_block[7:0];
   assign a1   = req_data.alpha_block[15:8];
   assign a_gt = (a0 > a1);

   always_comb begin
      for (int c = 0; c < 6; c++) begin
         if (a_gt) begin
            num_in[c] = 11'(a0) * 11'(6 - c) + 11'(a1) * 11'(c + 1);
         end else if (c < 4) begin
            num_in[c] = 11'(a0) * 11'(4 - c) + 11'(a1) * 11'(c + 1);
         end else begin
            num_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= FMT_BC1;
         width_ff    <= CSR_DATA_W'(1);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         fmt_ff      <= fmt_in;
         width_ff    <= width_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
         s1_fmt_ff <= fmt_ff;
         s1_col_ff <= col_now[BLOCK_POS_W-1:0];
         s1_row_ff <= row_now;
         s1_num_ff <= num_in;
         s1_gt_ff  <= a_gt;
      end
   end

   // stage 2: palettes, straight into the queue
   assign e0    = s1_req_ff.color_block[15:0];
   assign e1    = s1_req_ff.color_block[31:16];
   assign three = (e0 > e1);
   assign r0    = {1'b0, e0[15:11]};
   assign r1    = {1'b0, e1[15:11]};
   assign g0    = e0[10:5];
   assign g1    = e1[10:5];
   assign b0    = {1'b0, e0[4:0]};
   assign b1    = {1'b0, e1[4:0]};
   assign s1_a0 = s1_req_ff.alpha_block[7:0];
   assign s1_a1 = s1_req_ff.alpha_block[15:8];

   always_comb begin
      entry.fmt   = s1_fmt_ff;
      entry.cidx  = s1_req_ff.color_block[63:32];
      entry.abits = s1_req_ff.alpha_block;
      entry.col   = s1_col_ff;
      entry.row   = s1_row_ff;

      entry.pal_r[0] = r0[4:0];
      entry.pal_r[1] = r1[4:0];
      entry.pal_g[0] = g0;
      entry.pal_g[1] = g1;
      entry.pal_b[0] = b0[4:0];
      entry.pal_b[1] = b1[4:0];
      entry.pal_r[2] = 5'(mix(r0, r1, three, 1'b1));
      entry.pal_g[2] = mix(g0, g1, three, 1'b1);
      entry.pal_b[2] = 5'(mix(b0, b1, three, 1'b1));
      // slot 3 is black in three-color mode, when three is low
      entry.pal_r[3] = three ? 5'(mix(r0, r1, 1'b1, 1'b0)) : '0;
      entry.pal_g[3] = three ? mix(g0, g1, 1'b1, 1'b0) : '0;
      entry.pal_b[3] = three ? 5'(mix(b0, b1, 1'b1, 1'b0)) : '0;

      entry.apal[0] = s1_a0;
      entry.apal[1] = s1_a1;
      for (int c = 0; c < 6; c++) begin
         if (s1_gt_ff) begin
            entry.apal[c + 2] = div7(s1_num_ff[c]);
         end else if (c < 4) begin
            entry.apal[c + 2] = div5(s1_num_ff[c]);
         end else if (c == 4) begin
            entry.apal[c + 2] = 8'h00;
         end else begin
            entry.apal[c + 2] = 8'hFF;
         end
      end
   end

   `BCD_ASSERT_NEVER(a_col_range, 32'(col_ff) >= 32'(MAX_WIDTH_BLOCKS), "block column past row limit")

endmodule

// File: hw/rtl/bcd_back.sv
`include "bc1_bc2_bc3_block_decoder_assert.svh"

module bcd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bcd_pkg::bcd_qstat_type  qstat,
   input  bcd_pkg::bcd_entry_type  head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bcd_pkg::bcd_rsp_type    rsp_data
);
   import bcd_pkg::*;

   // v*255/31
   localparam logic [7:0] EXP5 [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   // v*255/63 = 4v + v/21
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] f;
      if (v == 6'd63) begin
         f = 2'd3;
      end else if (v >= 6'd42) begin
         f = 2'd2;
      end else if (v >= 6'd21) begin
         f = 2'd1;
      end else begin
         f = 2'd0;
      end
      return {v, 2'b00} + 8'(f);
   endfunction

   logic [3:0]       pix_ff, pix_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bcd_rsp_type      rsp_data_ff, rsp_data_in, pixel;
   logic             advance, load;
   logic [1:0]       ci;
   logic [15:0][3:0] nib;
   logic [15:0][2:0] aidx;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign load    = advance && qstat.not_empty;
   assign pop     = load && (pix_ff == 4'hF);

   assign nib  = head.abits;
   assign aidx = head.abits[63:16];
   assign ci   = head.cidx[pix_ff];

   always_comb begin
      pixel.red           = EXP5[head.pal_r[ci]];
      pixel.green         = expand6(head.pal_g[ci]);
      pixel.blue          = EXP5[head.pal_b[ci]];
      pixel.pixel_x       = {head.col, pix_ff[1:0]};
      pixel.pixel_y       = {head.row, pix_ff[3:2]};
      pixel.last_of_block = (pix_ff == 4'hF);
      unique case (head.fmt)
         FMT_BC1: pixel.alpha = 8'hFF;
         FMT_BC2: pixel.alpha = {nib[pix_ff], nib[pix_ff]};
         default: pixel.alpha = head.apal[aidx[pix_ff]];
      endcase
   end

   always_comb begin
      pix_in       = load ? pix_ff + 4'd1 : pix_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = load ? pixel : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_ff       <= pix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BCD_ASSERT_IMPLY(a_last_corner, rsp_valid_ff && rsp_data_ff.last_of_block, (rsp_data_ff.pixel_x[1:0] == 2'b11) && (rsp_data_ff.pixel_y[1:0] == 2'b11), "last pixel not at block corner")

endmodule

// File: tb/tb.sv
module tb;
   import bcd_pkg::*;

   // ------------------------------------------------------------------
   // Clock, reset and DUT hookup
   // ------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   bcd_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   bcd_rsp_type           rsp_data;
   logic                  csr_we;
   bcd_csr_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bc1_bc2_bc3_block_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------
   // shadow copy of the block's registers and block position
   logic [1:0]    shadow_format;
   logic [12:0]   shadow_width;
   int unsigned   pos_col;
   int unsigned   pos_row;

   bcd_rsp_type   expected_pixels [$];   // pixels owed by the DUT, oldest first
   int            err_count;
   int            blocks_sent;
   int            pixels_checked;

   bit            idle_on;      // both sides insert random gaps when set
   int            hold_count;   // cycles left of a forced rsp stall
   bit            rsp_hold;

   // ------------------------------------------------------------------
   // Block decode prediction
   // ------------------------------------------------------------------
   // One channel of the color palette: thirds in 4-color mode, halves otherwise.
   function automatic int unsigned blend(int unsigned a, int unsigned b, bit three, bit first);
      if (three) begin
         if (first) return (a * 2) / 3 + b / 3;
         return a / 3 + (b * 2) / 3;
      end
      return a / 2 + b / 2;
   endfunction

   // Expands one accepted block into its 16 pixels and advances the position.
   task automatic decode_block(input bcd_req_type blk);
      int unsigned pr [4];
      int unsigned pg [4];
      int unsigned pb [4];
      int unsigned apal [8];
      int unsigned e0, e1, ci, ai, w;
      bit          three;
      bcd_rsp_type px;
      if (blk.start_of_image) begin
         pos_col = 0;
         pos_row = 0;
      end
      e0 = blk.color_block[15:0];
      e1 = blk.color_block[31:16];
      three = e0 > e1;
      pr[0] = blk.color_block[15:11];
      pg[0] = blk.color_block[10:5];
      pb[0] = blk.color_block[4:0];
      pr[1] = blk.color_block[31:27];
      pg[1] = blk.color_block[26:21];
      pb[1] = blk.color_block[20:16];
      pr[2] = blend(pr[0], pr[1], three, 1'b1);
      pg[2] = blend(pg[0], pg[1], three, 1'b1);
      pb[2] = blend(pb[0], pb[1], three, 1'b1);
      // 3-color mode: index 3 is black
      pr[3] = three ? blend(pr[0], pr[1], 1'b1, 1'b0) : 0;
      pg[3] = three ? blend(pg[0], pg[1], 1'b1, 1'b0) : 0;
      pb[3] = three ? blend(pb[0], pb[1], 1'b1, 1'b0) : 0;

      apal[0] = blk.alpha_block[7:0];
      apal[1] = blk.alpha_block[15:8];
      if (apal[0] > apal[1]) begin
         for (int c = 2; c < 8; c++) apal[c] = ((8 - c) * apal[0] + (c - 1) * apal[1]) / 7;
      end else begin
         for (int c = 2; c < 6; c++) apal[c] = ((6 - c) * apal[0] + (c - 1) * apal[1]) / 5;
         apal[6] = 0;
         apal[7] = 255;
      end

      for (int j = 0; j < 16; j++) begin
         ci = blk.color_block[32 + 2 * j +: 2];
         px.red   = 8'((pr[ci] * 255) / 31);
         px.green = 8'((pg[ci] * 255) / 63);
         px.blue  = 8'((pb[ci] * 255) / 31);
         if (shadow_format == FMT_BC1) begin
            px.alpha = 8'd255;
         end else if (shadow_format == FMT_BC2) begin
            px.alpha = 8'(blk.alpha_block[4 * j +: 4] * 17);
         end else begin
            // BC3, and the unused fourth code decodes the same way
            ai = blk.alpha_block[16 + 3 * j +: 3];
            px.alpha = 8'(apal[ai]);
         end
         px.pixel_x       = 14'(pos_col * 4 + j % 4);
         px.pixel_y       = 14'(pos_row * 4 + j / 4);
         px.last_of_block = (j == 15);
         expected_pixels.push_back(px);
      end

      // width 0 acts as 1, anything past the maximum is clamped
      w = shadow_width;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH_BLOCKS_DEFAULT) w = MAX_WIDTH_BLOCKS_DEFAULT;
      if (pos_col + 1 >= w) begin
         pos_col = 0;
         pos_row = (pos_row + 1) & 12'hFFF;
      end else begin
         pos_col = pos_col + 1;
      end
      blocks_sent++;
   endtask

   // ------------------------------------------------------------------
   // Monitors: req acceptance feeds the prediction, rsp transactions are checked
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) decode_block(req_data);
   end

   task automatic report_mismatch(input string msg);
      err_count++;
      $display("tb: ERROR %s", msg);
   endtask

   always @(posedge clock) begin
      bcd_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
                                      rsp_data.pixel_x, rsp_data.pixel_y));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.red !== want.red)
               report_mismatch($sformatf("pixel %0d red %0d want %0d",
                                         pixels_checked, rsp_data.red, want.red));
            if (rsp_data.green !== want.green)
               report_mismatch($sformatf("pixel %0d green %0d want %0d",
                                         pixels_checked, rsp_data.green, want.green));
            if (rsp_data.blue !== want.blue)
               report_mismatch($sformatf("pixel %0d blue %0d want %0d",
                                         pixels_checked, rsp_data.blue, want.blue));
            if (rsp_data.alpha !== want.alpha)
               report_mismatch($sformatf("pixel %0d alpha %0d want %0d",
                                         pixels_checked, rsp_data.alpha, want.alpha));
            if (rsp_data.pixel_x !== want.pixel_x)
               report_mismatch($sformatf("pixel %0d x %0d want %0d",
                                         pixels_checked, rsp_data.pixel_x, want.pixel_x));
            if (rsp_data.pixel_y !== want.pixel_y)
               report_mismatch($sformatf("pixel %0d y %0d want %0d",
                                         pixels_checked, rsp_data.pixel_y, want.pixel_y));
            if (rsp_data.last_of_block !== want.last_of_block)
               report_mismatch($sformatf("pixel %0d last %0b want %0b", pixels_checked,
                                         rsp_data.last_of_block, want.last_of_block));
         end
         pixels_checked++;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random gaps per pixel, plus a forced long stall on request
   // ------------------------------------------------------------------
   initial begin
      rsp_hold = 0;
      forever begin
         @(posedge clock);
         if (hold_count > 0) begin
            rsp_hold = 1;
            hold_count--;
         end else begin
            rsp_hold = 0;
         end
      end
   end

   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = idle_on ? $urandom_range(0, 13) : 0;
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         while (rsp_hold) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
         // one rsp transaction completes on an edge with valid seen high
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Sender and register helpers
   // ------------------------------------------------------------------
   // Offers one block; valid stays high back to back when no gap is drawn.
   task automatic send_block(input logic [63:0] color, input logic [63:0] alpha,
                             input logic soi);
      int n;
      n = idle_on ? $urandom_range(0, 13) : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_data.color_block     <= color;
      req_data.alpha_block     <= alpha;
      req_data.start_of_image  <= soi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random_block();
      logic [63:0] c, a;
      c = {$urandom, $urandom};
      a = {$urandom, $urandom};
      // equal endpoints land in 3-color mode; equal alphas in the 6-entry palette
      if ($urandom_range(0, 3) == 0) c[31:16] = c[15:0];
      if ($urandom_range(0, 7) == 0) a[15:8] = a[7:0];
      send_block(c, a, $urandom_range(0, 15) == 0);
   endtask

   // Drops valid and waits out every owed pixel before any register change.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input bcd_csr_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_BLOCK_FORMAT) shadow_format = value[1:0];
      else shadow_width = value;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // BC1: 4-color, 3-color with black, equal endpoints, all-zero and all-one words
   task automatic test_bc1_palettes();
      idle_on = 1;
      csr_write(CSR_BLOCK_FORMAT, CSR_DATA_W'(FMT_BC1));
      csr_write(CSR_WIDTH_IN_BLOCKS, 13'd1);
      send_block(64'hE4E4_E4E4_0000_FFFF, {$urandom, $urandom}, 1'b1);
      send_block(64'h1B1B_1B1B_FFFF_0000, {$urandom, $urandom}, 1'b0);
      send_block(64'hE4E4_E4E4_7BEF_7BEF, {$urandom, $urandom}, 1'b0);
      send_block(64'h0000_0000_0000_0000, 64'h0, 1'b0);
      send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_block(64'hE4E4_E4E4_F81F_07E0, {$urandom, $urandom}, 1'b0);
      send_block(64'hE4E4_E4E4_0821_F7DE, {$urandom, $urandom}, 1'b0);
      wait_idle();
   endtask

   // BC2: every nibble value, all-clear and all-opaque
   task automatic test_bc2_alpha();
      csr_write(CSR_BLOCK_FORMAT, CSR_DATA_W'(FMT_BC2));
      send_block({$urandom, $urandom}, 64'hFEDC_BA98_7654_3210, 1'b0);
      send_block({$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_block({$urandom, $urandom}, 64'h0000_0000_0000_0000, 1'b0);
      wait_idle();
   endtask

   // BC3: indices 0..7 against 8-entry, 6-entry and equal-endpoint palettes;
   // format code 3 must decode as BC3
   task automatic test_bc3_alpha();
      csr_write(CSR_BLOCK_FORMAT, CSR_DATA_W'(FMT_BC3));
      send_block({$urandom, $urandom}, 64'hFAC6_88FA_C688_00FF, 1'b0);
      send_block({$urandom, $urandom}, 64'hFAC6_88FA_C688_FF00, 1'b0);
      send_block({$urandom, $urandom}, 64'hFAC6_88FA_C688_8080, 1'b0);
      send_block({$urandom, $urandom}, 64'hFAC6_88FA_C688_0DC8, 1'b0);
      wait_idle();
      csr_write(CSR_BLOCK_FORMAT, 13'd3);
      send_block({$urandom, $urandom}, 64'hFAC6_88FA_C688_21E7, 1'b0);
      wait_idle();
   endtask

   // Width 0 and over-range width, then a width lowered below the current column
   task automatic test_position_rules();
      csr_write(CSR_WIDTH_IN_BLOCKS, 13'd0);
      send_random_block();
      send_random_block();
      wait_idle();
      csr_write(CSR_WIDTH_IN_BLOCKS, 13'd8191);
      send_random_block();
      wait_idle();
      csr_write(CSR_WIDTH_IN_BLOCKS, 13'd10);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
      repeat (4) send_random_block();
      wait_idle();
      // column now 5, past the new width: next block still lands at column 5, the one after starts a new row
      csr_write(CSR_WIDTH_IN_BLOCKS, 13'd3);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      wait_idle();
   endtask

   // Start of a row at the maximum width: columns climb with no wrap
   task automatic test_column_sweep();
      idle_on = 0;
      csr_write(CSR_WIDTH_IN_BLOCKS, 13'd4096);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
      for (int i = 1; i < 8; i++) begin
         send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      end
      wait_idle();
   endtask

   // One block per row: the row counter steps on every block
   task automatic test_row_wrap();
      idle_on = 0;
      csr_write(CSR_WIDTH_IN_BLOCKS, 13'd1);
      send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
      for (int i = 1; i < 10; i++) begin
         send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      end
      wait_idle();
   endtask

   // Receiver stalls for a long stretch while blocks keep coming: queue fills,
   // req_ready must drop and nothing may be lost
   task automatic test_input_stall();
      idle_on = 0;
      csr_write(CSR_BLOCK_FORMAT, CSR_DATA_W'(FMT_BC3));
      csr_write(CSR_WIDTH_IN_BLOCKS, 13'd2);
      hold_count = 300;
      repeat (12) send_random_block();
      wait_idle();
   endtask

   // Random phases over formats and widths, gaps on or off per phase
   task automatic test_random_mix();
      for (int p = 0; p < 6; p++) begin
         csr_write(CSR_BLOCK_FORMAT, 13'($urandom_range(0, 3)));
         case ($urandom_range(0, 5))
            0: csr_write(CSR_WIDTH_IN_BLOCKS, 13'd0);
            1: csr_write(CSR_WIDTH_IN_BLOCKS, 13'd4096);
            2: csr_write(CSR_WIDTH_IN_BLOCKS, 13'd8191);
            3: csr_write(CSR_WIDTH_IN_BLOCKS, 13'($urandom_range(1, 8191)));
            default: csr_write(CSR_WIDTH_IN_BLOCKS, 13'($urandom_range(1, 6)));
         endcase
         idle_on = (p != 2) && ($urandom_range(0, 4) != 0);
         repeat (20) send_random_block();
         wait_idle();
      end
   endtask

   // ------------------------------------------------------------------
   // Run control
   // ------------------------------------------------------------------
   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_BLOCK_FORMAT;
      csr_wdata     = '0;
      shadow_format = FMT_BC1;
      shadow_width  = 13'd1;
      pos_col       = 0;
      pos_row       = 0;
      err_count     = 0;
      blocks_sent   = 0;
      pixels_checked = 0;
      idle_on       = 1;
      hold_count    = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bc1_palettes();
      test_bc2_alpha();
      test_bc3_alpha();
      test_position_rules();
      test_column_sweep();
      test_row_wrap();
      test_input_stall();
      test_random_mix();

      repeat (20) @(posedge clock);
      if (expected_pixels.size() != 0)
         report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
      $display("tb: %0d blocks decoded, %0d pixels compared, %0d mismatches",
               blocks_sent, pixels_checked, err_count);
      $display("tb: BC1/BC2/BC3 palettes, width clamps, row advance, rsp stall, random mix");
      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog: several times the slowest legal run
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: bc1_bc2_bc3_block_decoder.f
+incdir+hw/rtl
hw/rtl/bcd_pkg.sv
hw/rtl/bcd_queue.sv
hw/rtl/bcd_front.sv
hw/rtl/bcd_back.sv
hw/rtl/bc1_bc2_bc3_block_decoder.sv
tb/tb.sv
